>>> hdl/rwmf_pkg.sv
package rwmf_pkg;
  localparam int MAX_RADIUS_DEF = 2;
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int CFG_W = 11;
  localparam int IDX_W = 1;
  localparam logic [IDX_W-1:0] REG_RADIUS     = 1'b0;
  localparam logic [IDX_W-1:0] REG_LINE_WIDTH = 1'b1;
  localparam logic [1:0]  RADIUS_RESET = 2'd1;
  localparam logic [10:0] WIDTH_RESET  = 11'd640;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_start;
  } pix_word_t;
endpackage

>>> hdl/rwmf_if.sv
interface rwmf_pix_if import rwmf_pkg::*; ();
  logic      valid;
  logic      ready;
  pix_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rwmf_med_if import rwmf_pkg::*; ();
  logic valid;
  logic ready;
  rgb_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hdl/rwmf_sort_cell.sv
// One cell of a bitonic-free rank chain: holds an insertion-sorted list of
// one channel's window values; each stage inserts one new element.
module rwmf_sort_cell import rwmf_pkg::*; #(
  parameter int N = 25,
  parameter int K = 1
) (
  input  logic            clk,
  input  logic            en,
  input  logic [N*8-1:0]  vals_in,
  input  logic [7:0]      x_in,
  output logic [N*8-1:0]  vals_out
);
  // sorted prefix occupies slots 0..K-2; insert vals_in slot K-1 equivalent x_in
  logic [N*8-1:0] ins;
  always_comb begin
    logic [7:0] a;
    logic [7:0] prev;
    logic       placed;
    placed = 1'b0;
    prev   = 8'd0;
    ins    = vals_in;
    for (int i = 0; i < K; i++) begin
      a = vals_in[i*8 +: 8];
      if (i == K - 1) begin
        ins[i*8 +: 8] = placed ? prev : x_in;
      end else if (!placed && a > x_in) begin
        ins[i*8 +: 8] = x_in;
        prev = a;
        placed = 1'b1;
      end else if (placed) begin
        ins[i*8 +: 8] = prev;
        prev = a;
      end
    end
  end
  always_ff @(posedge clk) begin
    if (en) vals_out <= ins;
  end
endmodule

>>> hdl/rgb_window_median_filter.sv
// RGB median filter over a raster stream of pixels.
// Input channel pix_in carries one pixel word per handshake with
// frame_start marking the first pixel of an image. Output channel med_out
// carries the per-channel median of the (2r+1)^2 window centred r rows up
// and r columns left of the newest pixel; pixels within r of an edge give
// no word. Alpha is implied 0xFF.
// Throughput: one pixel per cycle while the receiver does not stall. The
// line store is one memory with a registered read; a pixel that follows
// one in the same column takes the column just written from a bypass
// register instead of the memory. The window of up to 25 values per
// channel is ranked by a chain of insertion cells, one new element a
// stage, whose last stage is the output register.
// The whole pipe advances only when the output register is free or taken,
// so a stalled receiver drops ready at once and nothing is lost.
// Reset clears the counters, valid bits and config (radius 1, width 640);
// line store and window contents are left undefined until written.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle.
module rgb_window_median_filter import rwmf_pkg::*; #(
  parameter int MAX_RADIUS = MAX_RADIUS_DEF,
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  rwmf_pix_if.sink         pix_in,
  rwmf_med_if.source       med_out
);
  localparam int LINES = 2 * MAX_RADIUS;
  localparam int SIDE  = 2 * MAX_RADIUS + 1;
  localparam int CELLS = SIDE * SIDE;
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int RAD_W = $clog2(MAX_RADIUS + 1);
  localparam int ROW_W = $clog2(LINES + 1);

  logic [1:0]  radius;
  logic [10:0] line_width;
  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RESET;
      line_width <= WIDTH_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_RADIUS) radius <= cfg_data[1:0];
      else line_width <= cfg_data;
    end
  end

  logic [RAD_W:0] r_eff;
  logic [11:0]    w_eff;
  always_comb begin
    r_eff = (32'(radius) > MAX_RADIUS) ? (RAD_W+1)'(MAX_RADIUS) : (RAD_W+1)'(radius);
    if (line_width == 11'd0) w_eff = 12'd1;
    else if (32'(line_width) > MAX_WIDTH) w_eff = 12'(MAX_WIDTH);
    else w_eff = {1'b0, line_width};
  end

  // pipe advances when the output slot is free or being taken
  logic adv;
  assign adv = !med_out.valid || med_out.ready;
  assign pix_in.ready = adv;
  logic acc;
  assign acc = pix_in.valid && adv;

  // stage 0: counters, memory read
  logic [COL_W:0] col_count;
  logic [ROW_W:0] row_count;
  logic [COL_W:0] col;
  logic [ROW_W:0] row_use;
  always_comb begin
    col = pix_in.data.frame_start ? '0 : col_count;
    row_use = pix_in.data.frame_start ? '0 : row_count;
    if (32'(col) >= 32'(w_eff)) col = '0;
  end

  logic [LINES*24-1:0] mem [MAX_WIDTH];
  logic [LINES*24-1:0] rd;
  logic [LINES*24-1:0] rd_mem;
  logic [LINES*24-1:0] rd_fwd;
  logic                s1_fwd;
  logic [LINES*24-1:0] shifted;
  logic [SIDE*24-1:0]  column;
  logic [COL_W-1:0]    s1_col;
  logic                s1_v, s1_emit;
  rgb_t                s1_pix;
  logic [ROW_W+1:0]    two_r;
  assign two_r = (ROW_W+2)'(r_eff) << 1;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      s1_v <= 1'b0;
    end else if (adv) begin
      s1_v <= acc;
      if (acc) begin
        if (32'(col) + 1 >= 32'(w_eff)) begin
          col_count <= '0;
          row_count <= (32'(row_use) < 32'(two_r)) ? row_use + 1'b1 : (ROW_W+1)'(two_r);
        end else begin
          col_count <= col + 1'b1;
          row_count <= row_use;
        end
      end
    end
  end

  // the memory write of the word in stage 1 lands on this same edge, so
  // take that column from the bypass when the addresses match
  always_ff @(posedge clk) begin
    if (adv && acc) begin
      rd_mem <= mem[col[COL_W-1:0]];
      rd_fwd <= shifted;
      s1_fwd <= s1_v && (s1_col == col[COL_W-1:0]);
      s1_col <= col[COL_W-1:0];
      s1_pix <= '{pix_in.data.red, pix_in.data.green, pix_in.data.blue};
      s1_emit <= (32'(row_use) >= 32'(two_r)) && (32'(col) >= 32'(two_r));
    end
  end
  assign rd = s1_fwd ? rd_fwd : rd_mem;

  // stage 1: write back shifted column, shift window
  assign column = {s1_pix, rd};
  if (LINES > 1) begin : g_sh
    assign shifted = {s1_pix, rd[LINES*24-1:24]};
  end else begin : g_sh1
    assign shifted = s1_pix;
  end
  always_ff @(posedge clk) begin
    if (adv && s1_v) mem[s1_col] <= shifted;
  end

  rgb_t win [SIDE][SIDE];
  always_ff @(posedge clk) begin
    if (adv && s1_v) begin
      for (int i = 0; i < SIDE; i++) begin
        for (int j = 0; j < SIDE - 1; j++) win[i][j] <= win[i][j+1];
        win[i][SIDE-1] <= column[i*24 +: 24];
      end
    end
  end
  // hold emit and radius with the shifted window
  logic s2_v;
  logic [RAD_W:0] s2_r;
  always_ff @(posedge clk) begin
    if (rst) s2_v <= 1'b0;
    else if (adv) s2_v <= s1_v && s1_emit;
  end
  always_ff @(posedge clk) begin
    if (adv) s2_r <= r_eff;
  end

  // gather active window elements, padding so median lands at fixed slot:
  // unused cells get alternately 0 and 255 pairs, keeping the middle rank.
  logic [CELLS*24-1:0] elems;
  always_comb begin
    int first;
    first = SIDE - 1 - 2 * int'(s2_r);
    elems = '0;
    for (int i = 0; i < SIDE; i++) begin
      for (int j = 0; j < SIDE; j++) begin
        if (i >= first && j >= first) elems[(i*SIDE+j)*24 +: 24] = win[i][j];
        else if (((i * SIDE + j) % 2) == 0) elems[(i*SIDE+j)*24 +: 24] = '1;
        else elems[(i*SIDE+j)*24 +: 24] = '0;
      end
    end
  end

  // chain of cells per channel
  logic [CELLS*8-1:0] sr [3][CELLS+1];
  logic [CELLS*24-1:0] pe [CELLS+1];
  logic                pv [CELLS+1];
  assign pe[0] = elems;
  assign pv[0] = s2_v;
  for (genvar c = 0; c < 3; c++) begin : g_ch
    assign sr[c][0] = '0;
    for (genvar k = 1; k <= CELLS; k++) begin : g_k
      rwmf_sort_cell #(.N(CELLS), .K(k)) u_cell (
        .clk(clk), .en(adv), .vals_in(sr[c][k-1]),
        .x_in(pe[k-1][(k-1)*24 + (2-c)*8 +: 8]), .vals_out(sr[c][k]));
    end
  end
  for (genvar k = 1; k <= CELLS; k++) begin : g_pp
    always_ff @(posedge clk) begin
      if (adv) pe[k] <= pe[k-1];
    end
    always_ff @(posedge clk) begin
      if (rst) pv[k] <= 1'b0;
      else if (adv) pv[k] <= pv[k-1];
    end
  end

  localparam int MID = (CELLS - 1) / 2;
  assign med_out.valid = pv[CELLS];
  assign med_out.data = '{sr[0][CELLS][MID*8 +: 8], sr[1][CELLS][MID*8 +: 8],
                          sr[2][CELLS][MID*8 +: 8]};

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    med_out.valid && !med_out.ready |=> med_out.valid && $stable(med_out.data))
    else $error("result changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    pix_in.ready == (!med_out.valid || med_out.ready))
    else $error("ready mismatch");
  a_col: assert property (@(posedge clk) disable iff (rst)
    32'(col_count) <= MAX_WIDTH) else $error("column out of range");
endmodule

>>> dv/rgb_window_median_filter_tb.sv
module rgb_window_median_filter_tb import rwmf_pkg::*; ();

  localparam int MAX_R      = MAX_RADIUS_DEF;
  localparam int MAX_W      = MAX_WIDTH_DEF;
  localparam int LINES      = 2 * MAX_R;
  localparam int SIDE       = 2 * MAX_R + 1;
  localparam int ITEM_GOAL  = 1400;
  localparam int QUIET_AT   = 1150;  // no idling once this many words went in
  localparam int HOLD_AT    = 400;   // long receiver stall starts here
  localparam int HOLD_LEN   = 300;
  localparam int DRAIN_WAIT = 2 + SIDE * SIDE + 20;
  localparam int CYCLE_CAP  = 400000;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  rwmf_pix_if pix_if ();
  rwmf_med_if med_if ();

  rgb_window_median_filter uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .pix_in(pix_if.sink),
    .med_out(med_if.source)
  );

  // Pixel words waiting for the driver, and medians waiting for the block.
  pix_word_t pixels_pending[$];
  rgb_t      medians_due[$];

  int words_queued;
  int words_accepted;
  int medians_seen;
  int mismatches;
  int cycles;
  int settings_used;

  // Shadow of the filter: config, line store, window and counters.
  logic [1:0]  sh_radius;
  logic [10:0] sh_width;
  rgb_t        sh_lines[LINES][MAX_W];
  rgb_t        sh_win[SIDE][SIDE];
  int          sh_col;
  int          sh_row;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Middle element of the first n bytes after sorting them.
  function automatic logic [7:0] middle_byte(logic [7:0] v[SIDE*SIDE], int n);
    logic [7:0] x;
    int j;
    for (int i = 1; i < n; i++) begin
      x = v[i];
      j = i;
      while (j > 0 && v[j-1] > x) begin
        v[j] = v[j-1];
        j--;
      end
      v[j] = x;
    end
    return v[(n - 1) / 2];
  endfunction

  // Advance the shadow by one accepted pixel; return 1 when a median is due.
  function automatic bit filter_pixel(pix_word_t p, output rgb_t med);
    int r, w, col, first, n;
    rgb_t column[SIDE];
    logic [7:0] rv[SIDE*SIDE], gv[SIDE*SIDE], bv[SIDE*SIDE];
    bit due;
    r = (sh_radius > MAX_R) ? MAX_R : sh_radius;
    w = sh_width;
    if (w < 1) w = 1;
    if (w > MAX_W) w = MAX_W;
    due = 1'b0;
    med = '0;
    if (p.frame_start) begin
      sh_col = 0;
      sh_row = 0;
    end
    if (sh_col >= w) sh_col = 0;
    col = sh_col;
    // vertical slice: stored lines oldest first, then the new pixel
    for (int k = 0; k < LINES; k++) column[k] = sh_lines[k][col];
    column[LINES] = '{red: p.red, green: p.green, blue: p.blue};
    for (int k = 0; k + 1 < LINES; k++) sh_lines[k][col] = sh_lines[k+1][col];
    sh_lines[LINES-1][col] = column[LINES];
    for (int i = 0; i < SIDE; i++) begin
      for (int j = 0; j + 1 < SIDE; j++) sh_win[i][j] = sh_win[i][j+1];
      sh_win[i][SIDE-1] = column[i];
    end
    if (sh_row >= 2 * r && col >= 2 * r) begin
      first = SIDE - 1 - 2 * r;
      n = 0;
      for (int i = first; i < SIDE; i++)
        for (int j = first; j < SIDE; j++) begin
          rv[n] = sh_win[i][j].red;
          gv[n] = sh_win[i][j].green;
          bv[n] = sh_win[i][j].blue;
          n++;
        end
      med.red   = middle_byte(rv, n);
      med.green = middle_byte(gv, n);
      med.blue  = middle_byte(bv, n);
      due = 1'b1;
    end
    sh_col = col + 1;
    if (sh_col >= w) begin
      sh_col = 0;
      if (sh_row < 2 * r) sh_row = sh_row + 1;
      else sh_row = 2 * r;
    end
    return due;
  endfunction

  // Driver: pop a word when the channel is free, with random gap bursts.
  int send_gap;
  always @(posedge clk) begin
    logic nxt_valid;
    pix_word_t nxt_word;
    rgb_t med;
    if (rst) begin
      pix_if.valid <= 1'b0;
      pix_if.data  <= '0;
      send_gap = 0;
    end else begin
      if (pix_if.valid && pix_if.ready) begin
        words_accepted++;
        if (filter_pixel(pix_if.data, med)) medians_due.push_back(med);
      end
      if (!pix_if.valid || pix_if.ready) begin
        nxt_valid = 1'b0;
        nxt_word  = pix_if.data;
        if (send_gap > 0) begin
          send_gap--;
        end else if (pixels_pending.size() > 0) begin
          nxt_valid = 1'b1;
          nxt_word  = pixels_pending.pop_front();
          // start an idle burst after this word now and then
          if (words_accepted < QUIET_AT && $urandom_range(0, 9) == 0)
            send_gap = $urandom_range(1, 3);
        end
        pix_if.valid <= nxt_valid;
        pix_if.data  <= nxt_word;
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off to fill the pipe.
  int  recv_gap;
  int  hold_left;
  bit  hold_done;
  always @(posedge clk) begin
    logic nxt_ready;
    if (rst) begin
      med_if.ready <= 1'b0;
      recv_gap = 0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      if (!hold_done && words_accepted >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
      end
      nxt_ready = 1'b1;
      if (hold_left > 0) begin
        hold_left--;
        nxt_ready = 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        nxt_ready = 1'b0;
      end else if (words_accepted < QUIET_AT && $urandom_range(0, 7) == 0) begin
        recv_gap = $urandom_range(0, 2);
        nxt_ready = 1'b0;
      end
      med_if.ready <= nxt_ready;
    end
  end

  // Monitor: check each median word against the oldest one due.
  always @(posedge clk) begin
    rgb_t want;
    if (!rst && med_if.valid && med_if.ready) begin
      medians_seen++;
      if (medians_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected median word r=%0d g=%0d b=%0d",
                   med_if.data.red, med_if.data.green, med_if.data.blue);
      end else begin
        want = medians_due.pop_front();
        if (med_if.data.red !== want.red || med_if.data.green !== want.green ||
            med_if.data.blue !== want.blue) begin
          mismatches++;
          if (mismatches <= 10)
            $display("median mismatch: want r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
                     want.red, want.green, want.blue,
                     med_if.data.red, med_if.data.green, med_if.data.blue);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Hold the sender until every word went in and every median came out,
  // then let the pipe run dry, since a pixel may still be in flight.
  task automatic wait_drained();
    do @(posedge clk);
    while (pixels_pending.size() > 0 || pix_if.valid || words_accepted < words_queued ||
           medians_due.size() > 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == REG_RADIUS) sh_radius = val[1:0];
    else sh_width = val;
    @(posedge clk);
  endtask

  task automatic set_mode(logic [1:0] r, logic [10:0] w);
    wait_drained();
    write_reg(REG_RADIUS, CFG_W'(r));
    write_reg(REG_LINE_WIDTH, w);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic push_pixel(logic [7:0] rd, logic [7:0] gr, logic [7:0] bl, logic fs);
    pixels_pending.push_back('{red: rd, green: gr, blue: bl, frame_start: fs});
    words_queued++;
  endtask

  // Queue one image of random content, opening with frame_start; a few
  // stray frame starts land mid-line as noise.
  task automatic push_image(int count);
    for (int i = 0; i < count; i++)
      push_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)),
                 (i == 0) || ($urandom_range(0, 99) == 0));
  endtask

  initial begin
    int r, w, weff, rows;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pix_if.valid = 1'b0;
    pix_if.data = '0;
    med_if.ready = 1'b0;
    sh_radius = RADIUS_RESET;
    sh_width = WIDTH_RESET;
    sh_col = 0;
    sh_row = 0;
    words_queued = 0;
    words_accepted = 0;
    medians_seen = 0;
    mismatches = 0;
    cycles = 0;
    settings_used = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: radius zero echoes every pixel; field extremes and a
    // frame start in mid-line.
    set_mode(2'd0, 11'd16);
    push_pixel(8'h00, 8'h00, 8'h00, 1'b1);
    push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    push_pixel(8'hFF, 8'h00, 8'h00, 1'b0);
    push_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
    push_pixel(8'h00, 8'h00, 8'hFF, 1'b0);
    push_pixel(8'hAA, 8'h55, 8'hAA, 1'b0);
    push_pixel(8'h55, 8'hAA, 8'h55, 1'b1);
    push_pixel(8'h01, 8'h80, 8'h7F, 1'b0);
    push_image(12);

    // Fixed settings: small radii, saturated radius, clamped widths.
    set_mode(2'd1, 11'd16);
    push_image(16 * 4);
    set_mode(2'd2, 11'd16);
    push_image(16 * 6);
    set_mode(2'd3, 11'd20);
    push_image(20 * 6);
    set_mode(2'd1, 11'd0);     // width clamps to one: nothing comes out
    push_image(20);
    set_mode(2'd0, 11'd2047);  // width clamps to the maximum
    push_image(150);
    set_mode(2'd2, 11'd1024);
    push_image(80);

    // Random settings and images until the word goal is reached.
    while (words_queued < ITEM_GOAL) begin
      r = $urandom_range(0, 3);
      if ($urandom_range(0, 9) == 0) w = $urandom_range(0, 2047);
      else w = $urandom_range(16, 40);
      weff = (w < 1) ? 1 : ((w > MAX_W) ? MAX_W : w);
      rows = 2 * ((r > MAX_R) ? MAX_R : r) + 1 + $urandom_range(0, 2);
      set_mode(r[1:0], w[10:0]);
      push_image((rows * weff > 240) ? 240 : rows * weff);
    end

    wait_drained();
    $display("covered %0d pixel words and %0d median words over %0d settings",
             words_accepted, medians_seen, settings_used);
    $display("radius 0..3, widths 0..2047, receiver hold of %0d cycles, mid-line frame starts",
             HOLD_LEN);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
